@@ rtl/core/wpmmd_pkg.sv @@
// Shared types, register codes and format constants for the min/max peak decimator.
package wpmmd_pkg;

  localparam int MAX_CHUNK_LOG2_DEF = 24;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_INPUT_FORMAT  = 2'd0;
  localparam logic [1:0] REG_OUTPUT_FORMAT = 2'd1;
  localparam logic [1:0] REG_CHUNK_LOG2    = 2'd2;

  localparam logic [1:0] IN_FMT_S8  = 2'd0;
  localparam logic [1:0] IN_FMT_S16 = 2'd1;
  localparam logic [1:0] IN_FMT_S32 = 2'd2;

  localparam logic OUT_FMT_S8  = 1'b0;
  localparam logic OUT_FMT_S16 = 1'b1;

  localparam logic [1:0] INPUT_FORMAT_RST  = IN_FMT_S16;
  localparam logic       OUTPUT_FORMAT_RST = OUT_FMT_S8;
  localparam logic [4:0] CHUNK_LOG2_RST    = 5'd1;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic               last_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] first_value;
    logic signed [15:0] second_value;
    logic               channel_end;
  } out_word_t;

  function automatic logic signed [15:0] fmt_max(input logic ofmt);
    fmt_max = (ofmt == OUT_FMT_S16) ? 16'sh7fff : 16'sh007f;
  endfunction

  function automatic logic signed [15:0] fmt_min(input logic ofmt);
    fmt_min = (ofmt == OUT_FMT_S16) ? 16'sh8000 : 16'shff80;
  endfunction

endpackage

@@ rtl/core/waveform_peak_min_max_decimator_core.sv @@
// Top level: rescale pipeline, running min/max per chunk and APB register file.
//
//  channel  | handshake           | word
//  ---------+---------------------+---------------------------------------------
//  in       | in_valid / in_stall | in_data: sample_value, last_sample
//  out      | out_valid/out_stall | out_data: first_value, second_value, channel_end
//  config   | APB psel/penable    | input_format, output_format, chunk_log2
//
// One sample per cycle while no result is stalled. The accepting edge loads the input reg;
// the product reg, rescaled-value reg and result reg follow in that order.
// The 31x15 multiply for positive rescaling sets the product stage.
// rst (synchronous) restores register defaults and restarts the chunk.
// A stalled result freezes the whole pipeline; in_stall follows it.
module waveform_peak_min_max_decimator_core #(
  parameter int MAX_CHUNK_LOG2 = wpmmd_pkg::MAX_CHUNK_LOG2_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  wpmmd_pkg::in_word_t                  in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output wpmmd_pkg::out_word_t                 out_data,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [wpmmd_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [wpmmd_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [wpmmd_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                 pready
);
  import wpmmd_pkg::*;

  localparam int PW = MAX_CHUNK_LOG2;
  localparam int CW = $clog2(MAX_CHUNK_LOG2 + 1);

  // ---------------- configuration ----------------
  logic [1:0] input_format;
  logic       output_format;
  logic [4:0] chunk_log2;
  logic       cfg_wr;
  logic [1:0] reg_idx;
  logic       cfg_hit;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_hit = cfg_wr && (reg_idx == REG_INPUT_FORMAT || reg_idx == REG_OUTPUT_FORMAT ||
                              reg_idx == REG_CHUNK_LOG2);

  always_ff @(posedge clk) begin
    if (rst) begin
      input_format  <= INPUT_FORMAT_RST;
      output_format <= OUTPUT_FORMAT_RST;
      chunk_log2    <= CHUNK_LOG2_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_INPUT_FORMAT:  input_format  <= pwdata[1:0];
        REG_OUTPUT_FORMAT: output_format <= pwdata[0];
        REG_CHUNK_LOG2:    chunk_log2    <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_INPUT_FORMAT:  prdata = {30'd0, input_format};
      REG_OUTPUT_FORMAT: prdata = {31'd0, output_format};
      REG_CHUNK_LOG2:    prdata = {27'd0, chunk_log2};
      default:           prdata = '0;
    endcase
  end

  logic iw8, iw16, ow16;
  assign iw8  = (input_format == IN_FMT_S8);
  assign iw16 = (input_format == IN_FMT_S16);
  assign ow16 = (output_format == OUT_FMT_S16);

  // ---------------- pipeline control ----------------
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage 1: input register
  logic        valid1, last1;
  logic [31:0] raw1;

  always_ff @(posedge clk) begin
    if (rst) valid1 <= 1'b0;
    else if (adv) valid1 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      raw1  <= in_data.sample_value;
      last1 <= in_data.last_sample;
    end
  end

  // stage 1 -> 2: sign extend, magnitude, product, negative path
  logic [31:0] sext;
  logic        neg;
  logic [31:0] mag;
  logic [16:0] nmag;
  logic [45:0] prod;
  logic [14:0] omax15;

  always_comb begin
    unique case (input_format)
      IN_FMT_S8:  sext = {{24{raw1[7]}}, raw1[7:0]};
      IN_FMT_S16: sext = {{16{raw1[15]}}, raw1[15:0]};
      default:    sext = raw1;
    endcase
    neg    = sext[31];
    mag    = neg ? (~sext + 32'd1) : sext;
    omax15 = ow16 ? 15'h7fff : 15'h007f;
    prod   = mag[30:0] * omax15;
    // exact power-of-two ratio for negative samples
    if (iw8) nmag = ow16 ? {mag[8:0], 8'd0} : mag[16:0];
    else if (iw16) nmag = ow16 ? mag[16:0] : {8'd0, mag[16:8]};
    else nmag = ow16 ? {1'b0, mag[31:16]} : {9'd0, mag[31:24]};
  end

  logic               valid2, last2, neg2;
  logic [15:0]        mag2;
  logic [45:0]        prod2;
  logic signed [15:0] negv2;

  always_ff @(posedge clk) begin
    if (rst) valid2 <= 1'b0;
    else if (adv) valid2 <= valid1;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      last2 <= last1;
      neg2  <= neg;
      mag2  <= mag[15:0];
      prod2 <= prod;
      negv2 <= 16'(~nmag + 17'd1);
    end
  end

  // stage 2 -> 3: divide by 2^k-1 as (x + (x>>k) + 1) >> k, valid for x < 2^(2k)-1
  logic [46:0]        t15, t31;
  logic signed [15:0] v;

  always_comb begin
    t15 = {1'b0, prod2} + 47'(prod2 >> 15) + 47'd1;
    t31 = {1'b0, prod2} + 47'(prod2 >> 31) + 47'd1;
    if (neg2) v = negv2;
    else if ((iw8 && !ow16) || (iw16 && ow16)) v = mag2;
    else if (iw8) v = {1'b0, mag2[6:0], 8'd0} + {8'd0, mag2[6:0], 1'b0} +
                      16'(mag2[6:0] == 7'h7f);
    else if (iw16) v = t15[30:15];
    else v = t31[46:31];
  end

  logic               valid3, last3;
  logic signed [15:0] v3;

  always_ff @(posedge clk) begin
    if (rst) valid3 <= 1'b0;
    else if (adv) valid3 <= valid2;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      last3 <= last2;
      v3    <= v;
    end
  end

  // ---------------- running min/max ----------------
  logic signed [15:0] running_min, running_max, running_min_next, running_max_next;
  logic [PW-1:0]      min_position, max_position, chunk_position;
  logic [PW-1:0]      min_position_next, max_position_next, pos_mask;
  logic [CW-1:0]      cbits;
  logic               chunk_done;

  always_comb begin
    if (chunk_log2 == 5'd0) cbits = CW'(1);
    else if (int'(chunk_log2) > MAX_CHUNK_LOG2) cbits = CW'(MAX_CHUNK_LOG2);
    else cbits = CW'(chunk_log2);
    pos_mask   = ~({PW{1'b1}} << cbits);
    chunk_done = last3 || (chunk_position == pos_mask);

    running_min_next  = running_min;
    min_position_next = min_position;
    running_max_next  = running_max;
    max_position_next = max_position;
    if (v3 < running_min) begin
      running_min_next  = v3;
      min_position_next = chunk_position;
    end
    if (v3 > running_max) begin
      running_max_next  = v3;
      max_position_next = chunk_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit || (adv && valid3 && chunk_done)) begin
      running_min    <= rst ? fmt_max(OUTPUT_FORMAT_RST) :
                        cfg_hit ? fmt_max(reg_idx == REG_OUTPUT_FORMAT ? pwdata[0] : output_format)
                                : fmt_max(output_format);
      running_max    <= rst ? fmt_min(OUTPUT_FORMAT_RST) :
                        cfg_hit ? fmt_min(reg_idx == REG_OUTPUT_FORMAT ? pwdata[0] : output_format)
                                : fmt_min(output_format);
      min_position   <= '0;
      max_position   <= '0;
      chunk_position <= '0;
    end else if (adv && valid3) begin
      running_min    <= running_min_next;
      running_max    <= running_max_next;
      min_position   <= min_position_next;
      max_position   <= max_position_next;
      chunk_position <= chunk_position + PW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= valid3 && chunk_done;
  end
  always_ff @(posedge clk) begin
    if (adv && valid3 && chunk_done) begin
      if (max_position_next < min_position_next) begin
        out_data.first_value  <= running_max_next;
        out_data.second_value <= running_min_next;
      end else begin
        out_data.first_value  <= running_min_next;
        out_data.second_value <= running_max_next;
      end
      out_data.channel_end <= last3;
    end
  end

endmodule

@@ rtl/core/wpmmd_checker.sv @@
// Port-level checker for the min/max peak decimator, bound to the top level.
module wpmmd_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input wpmmd_pkg::out_word_t out_data
);
  import wpmmd_pkg::*;

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // nothing leaves the block right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // input only backs up behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no blocked result");

endmodule

bind waveform_peak_min_max_decimator_core wpmmd_checker u_wpmmd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
